FILE: rtl/core/gea_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gea_pkg
// Shared constants and types for the gather-elements address generator.
// ----------------------------------------------------------------------------
package gea_pkg;

    // Default geometry, handed to the top-level parameters
    localparam int DEF_MAX_DIMS = 4;
    localparam int DEF_EXTENT_W = 16;
    localparam int DEF_ADDR_W   = 32;

    // Fixed field widths
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int AXIS_W     = 2;
    localparam int INDEX_W    = 32;
    localparam int OUT_ADDR_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GATHER_AXIS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_EXTENTS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_EXTENTS  = 2'd2;

    // All four extents equal to one
    localparam logic [CFG_W-1:0] EXTENTS_RESET = 64'h0001_0001_0001_0001;

    // Per-item status that rides along the pipeline
    typedef struct packed {
        logic bad;
        logic last;
    } t_flags;

endpackage
`default_nettype wire

FILE: rtl/core/gea_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gea_in_if
// Index item channel: valid/ready handshake with index value and restart flag.
// ----------------------------------------------------------------------------
interface gea_in_if import gea_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic signed [INDEX_W-1:0] index_value;
    logic                      first_item;

    modport source (
        output valid,
        output index_value,
        output first_item,
        input  ready
    );

    modport sink (
        input  valid,
        input  index_value,
        input  first_item,
        output ready
    );

endinterface
`default_nettype wire

FILE: rtl/core/gea_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gea_out_if
// Address result channel: valid/ready handshake with addresses and flags.
// ----------------------------------------------------------------------------
interface gea_out_if import gea_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [OUT_ADDR_W-1:0] source_address;
    logic [OUT_ADDR_W-1:0] dest_address;
    logic                  index_bad;
    logic                  last_item;

    modport source (
        output valid,
        output source_address,
        output dest_address,
        output index_bad,
        output last_item,
        input  ready
    );

    modport sink (
        input  valid,
        input  source_address,
        input  dest_address,
        input  index_bad,
        input  last_item,
        output ready
    );

endinterface
`default_nettype wire

FILE: rtl/core/gea_odometer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gea_odometer
// Input stage: coordinate odometer and linear counter over the index shape.
// ----------------------------------------------------------------------------
module gea_odometer import gea_pkg::*; #(
    parameter int MAX_DIMS = DEF_MAX_DIMS,
    parameter int EXTENT_W = DEF_EXTENT_W,
    parameter int ADDR_W   = DEF_ADDR_W
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic [MAX_DIMS-1:0][EXTENT_W-1:0]  i_idx_ext,
    input  wire logic                               i_valid,
    output      logic                               o_ready,
    input  wire logic signed [INDEX_W-1:0]          i_index_value,
    input  wire logic                               i_first_item,
    output      logic                               o_valid,
    input  wire logic                               i_ready,
    output      logic signed [INDEX_W-1:0]          o_index_value,
    output      logic [MAX_DIMS-1:0][EXTENT_W-1:0]  o_coord,
    output      logic [ADDR_W-1:0]                  o_dest,
    output      logic                               o_last
);

    localparam int EW1 = EXTENT_W + 1;

    logic                              r_valid;
    logic [MAX_DIMS-1:0][EXTENT_W-1:0] r_coord;
    logic [ADDR_W-1:0]                 r_lin;
    logic signed [INDEX_W-1:0]         r_index;
    logic [MAX_DIMS-1:0][EXTENT_W-1:0] r_item_coord;
    logic [ADDR_W-1:0]                 r_dest;
    logic                              r_last;

    logic [MAX_DIMS-1:0][EXTENT_W-1:0] cur;
    logic [ADDR_W-1:0]                 cur_lin;
    logic [MAX_DIMS-1:0]               room;
    logic                              carry;
    logic [MAX_DIMS-1:0][EXTENT_W-1:0] n_coord;
    logic [ADDR_W-1:0]                 n_lin;
    logic                              n_last;
    logic                              accept;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        cur     = i_first_item ? '0 : r_coord;
        cur_lin = i_first_item ? '0 : r_lin;
        for (int d = 0; d < MAX_DIMS; d++) begin
            // extent of zero or one counts as finished
            room[d] = (EW1'(cur[d]) + EW1'(1)) < EW1'(i_idx_ext[d]);
        end
        n_last = ~|room;
        carry  = 1'b1;
        for (int d = MAX_DIMS - 1; d >= 0; d--) begin
            if (!carry) begin
                n_coord[d] = cur[d];
            end else if (room[d]) begin
                n_coord[d] = cur[d] + EXTENT_W'(1);
                carry      = 1'b0;
            end else begin
                n_coord[d] = '0;
            end
        end
        n_lin = n_last ? '0 : cur_lin + ADDR_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_coord <= '0;
            r_lin   <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (accept) begin
                r_coord <= n_coord;
                r_lin   <= n_lin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_index      <= i_index_value;
            r_item_coord <= cur;
            r_dest       <= cur_lin;
            r_last       <= n_last;
        end
    end

    assign o_valid       = r_valid;
    assign o_index_value = r_index;
    assign o_coord       = r_item_coord;
    assign o_dest        = r_dest;
    assign o_last        = r_last;

endmodule
`default_nettype wire

FILE: rtl/core/gea_index_wrap.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gea_index_wrap
// Wrap a negative index by the axis extent, flag an index still out of range,
// and replace the axis coordinate of the source position.
// ----------------------------------------------------------------------------
module gea_index_wrap import gea_pkg::*; #(
    parameter int MAX_DIMS = DEF_MAX_DIMS,
    parameter int EXTENT_W = DEF_EXTENT_W,
    parameter int ADDR_W   = DEF_ADDR_W
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic [AXIS_W-1:0]                  i_axis,
    input  wire logic [MAX_DIMS-1:0][EXTENT_W-1:0]  i_data_ext,
    input  wire logic                               i_valid,
    output      logic                               o_ready,
    input  wire logic signed [INDEX_W-1:0]          i_index_value,
    input  wire logic [MAX_DIMS-1:0][EXTENT_W-1:0]  i_coord,
    input  wire logic [ADDR_W-1:0]                  i_dest,
    input  wire logic                               i_last,
    output      logic                               o_valid,
    input  wire logic                               i_ready,
    output      logic [MAX_DIMS-1:0][EXTENT_W-1:0]  o_coord,
    output      logic [ADDR_W-1:0]                  o_dest,
    output      t_flags                             o_flags
);

    localparam int WRAP_W = INDEX_W + 1;

    logic                              r_valid;
    logic [MAX_DIMS-1:0][EXTENT_W-1:0] r_coord;
    logic [ADDR_W-1:0]                 r_dest;
    t_flags                            r_flags;

    logic                              has_axis;
    logic [EXTENT_W-1:0]               axis_ext;
    logic [WRAP_W-1:0]                 wrapped;
    logic                              bad;
    logic [MAX_DIMS-1:0][EXTENT_W-1:0] n_coord;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        has_axis = 32'(i_axis) < 32'(MAX_DIMS);
        axis_ext = '0;
        for (int d = 0; d < MAX_DIMS; d++) begin
            if (32'(d) == 32'(i_axis)) begin
                axis_ext = i_data_ext[d];
            end
        end
        wrapped = WRAP_W'(i_index_value)
                + (i_index_value[INDEX_W-1] ? WRAP_W'(axis_ext) : WRAP_W'(0));
        bad = has_axis && (wrapped[WRAP_W-1] ||
                           (wrapped[INDEX_W-1:0] >= INDEX_W'(axis_ext)));
        n_coord = i_coord;
        for (int d = 0; d < MAX_DIMS; d++) begin
            if (has_axis && (32'(d) == 32'(i_axis))) begin
                n_coord[d] = bad ? '0 : wrapped[EXTENT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_coord      <= n_coord;
            r_dest       <= i_dest;
            r_flags.bad  <= bad;
            r_flags.last <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_coord = r_coord;
    assign o_dest  = r_dest;
    assign o_flags = r_flags;

endmodule
`default_nettype wire

FILE: rtl/core/gea_mac_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gea_mac_stage
// One Horner step of the source offset: acc * extent + coordinate.
// ----------------------------------------------------------------------------
module gea_mac_stage import gea_pkg::*; #(
    parameter int MAX_DIMS = DEF_MAX_DIMS,
    parameter int EXTENT_W = DEF_EXTENT_W,
    parameter int ADDR_W   = DEF_ADDR_W,
    parameter int STAGE    = 0
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic [EXTENT_W-1:0]                i_ext,
    input  wire logic                               i_valid,
    output      logic                               o_ready,
    input  wire logic [ADDR_W-1:0]                  i_acc,
    input  wire logic [MAX_DIMS-1:0][EXTENT_W-1:0]  i_coord,
    input  wire logic [ADDR_W-1:0]                  i_dest,
    input  wire t_flags                             i_flags,
    output      logic                               o_valid,
    input  wire logic                               i_ready,
    output      logic [ADDR_W-1:0]                  o_acc,
    output      logic [MAX_DIMS-1:0][EXTENT_W-1:0]  o_coord,
    output      logic [ADDR_W-1:0]                  o_dest,
    output      t_flags                             o_flags
);

    localparam bit IS_FINAL = (STAGE == MAX_DIMS - 1);

    logic                              r_valid;
    logic [ADDR_W-1:0]                 r_acc;
    logic [MAX_DIMS-1:0][EXTENT_W-1:0] r_coord;
    logic [ADDR_W-1:0]                 r_dest;
    t_flags                            r_flags;

    logic [ADDR_W-1:0] prod;
    logic [ADDR_W-1:0] n_acc;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        prod  = i_acc * ADDR_W'(i_ext);
        n_acc = prod + ADDR_W'(i_coord[STAGE]);
        // a bad index points at offset zero
        if (IS_FINAL && i_flags.bad) begin
            n_acc = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_acc   <= n_acc;
            r_coord <= i_coord;
            r_dest  <= i_dest;
            r_flags <= i_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_acc   = r_acc;
    assign o_coord = r_coord;
    assign o_dest  = r_dest;
    assign o_flags = r_flags;

endmodule
`default_nettype wire

FILE: rtl/core/gather_elements_address_generator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gather_elements_address_generator_top
// GatherElements address generator: source and destination offsets per index.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while o_out.ready holds; every stage is
// registered with its own valid/ready, so the odometer, the wrap stage and
// the MAX_DIMS multiply-add stages each hold one item and bubbles collapse
// under backpressure.
// Reset (synchronous, active low): axis 0, all extents 1, odometer and linear
// counter at zero, pipeline empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
module gather_elements_address_generator_top import gea_pkg::*; #(
    parameter int MAX_DIMS = DEF_MAX_DIMS,
    parameter int EXTENT_W = DEF_EXTENT_W,
    parameter int ADDR_W   = DEF_ADDR_W
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,
    gea_in_if.sink                    i_in,
    gea_out_if.source                 o_out
);

    // ------------------------------------------------------------------
    // Configuration registers; writes take effect on the next edge
    // ------------------------------------------------------------------
    logic [AXIS_W-1:0] r_axis;
    logic [CFG_W-1:0]  r_index_ext;
    logic [CFG_W-1:0]  r_data_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis      <= '0;
            r_index_ext <= EXTENTS_RESET;
            r_data_ext  <= EXTENTS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GATHER_AXIS:   r_axis      <= i_cfg_wdata[AXIS_W-1:0];
                CFG_INDEX_EXTENTS: r_index_ext <= i_cfg_wdata;
                CFG_DATA_EXTENTS:  r_data_ext  <= i_cfg_wdata;
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Unpack extents, outermost dimension in the highest field. A field
    // that would lie above the packed word reads as zero.
    // ------------------------------------------------------------------
    logic [MAX_DIMS-1:0][EXTENT_W-1:0] idx_ext;
    logic [MAX_DIMS-1:0][EXTENT_W-1:0] data_ext;

    for (genvar d = 0; d < MAX_DIMS; d++) begin : g_unpack
        localparam int SHIFT = (MAX_DIMS - 1 - d) * EXTENT_W;
        if (SHIFT >= CFG_W) begin : g_zero
            assign idx_ext[d]  = '0;
            assign data_ext[d] = '0;
        end else begin : g_field
            assign idx_ext[d]  = EXTENT_W'(r_index_ext >> SHIFT);
            assign data_ext[d] = EXTENT_W'(r_data_ext >> SHIFT);
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: odometer, assigns coordinates and destination offset
    // ------------------------------------------------------------------
    logic                              od_valid;
    logic                              od_ready;
    logic signed [INDEX_W-1:0]         od_index;
    logic [MAX_DIMS-1:0][EXTENT_W-1:0] od_coord;
    logic [ADDR_W-1:0]                 od_dest;
    logic                              od_last;

    gea_odometer #(
        .MAX_DIMS (MAX_DIMS),
        .EXTENT_W (EXTENT_W),
        .ADDR_W   (ADDR_W)
    ) u_odometer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_idx_ext     (idx_ext),
        .i_valid       (i_in.valid),
        .o_ready       (i_in.ready),
        .i_index_value (i_in.index_value),
        .i_first_item  (i_in.first_item),
        .o_valid       (od_valid),
        .i_ready       (od_ready),
        .o_index_value (od_index),
        .o_coord       (od_coord),
        .o_dest        (od_dest),
        .o_last        (od_last)
    );

    // ------------------------------------------------------------------
    // Stage 1: wrap the index and build the source coordinates.
    // Its outputs feed slot 0 of the multiply-add chain.
    // ------------------------------------------------------------------
    logic                              s_valid [MAX_DIMS+1];
    logic                              s_ready [MAX_DIMS+1];
    logic [ADDR_W-1:0]                 s_acc   [MAX_DIMS+1];
    logic [MAX_DIMS-1:0][EXTENT_W-1:0] s_coord [MAX_DIMS+1];
    logic [ADDR_W-1:0]                 s_dest  [MAX_DIMS+1];
    t_flags                            s_flags [MAX_DIMS+1];

    gea_index_wrap #(
        .MAX_DIMS (MAX_DIMS),
        .EXTENT_W (EXTENT_W),
        .ADDR_W   (ADDR_W)
    ) u_index_wrap (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_axis        (r_axis),
        .i_data_ext    (data_ext),
        .i_valid       (od_valid),
        .o_ready       (od_ready),
        .i_index_value (od_index),
        .i_coord       (od_coord),
        .i_dest        (od_dest),
        .i_last        (od_last),
        .o_valid       (s_valid[0]),
        .i_ready       (s_ready[0]),
        .o_coord       (s_coord[0]),
        .o_dest        (s_dest[0]),
        .o_flags       (s_flags[0])
    );

    // Horner accumulation starts from zero
    assign s_acc[0] = '0;

    // ------------------------------------------------------------------
    // Stages 2 .. MAX_DIMS+1: source offset by Horner's rule over the
    // data extents, one dimension per stage, outermost first
    // ------------------------------------------------------------------
    for (genvar k = 0; k < MAX_DIMS; k++) begin : g_mac
        gea_mac_stage #(
            .MAX_DIMS (MAX_DIMS),
            .EXTENT_W (EXTENT_W),
            .ADDR_W   (ADDR_W),
            .STAGE    (k)
        ) u_mac (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ext   (data_ext[k]),
            .i_valid (s_valid[k]),
            .o_ready (s_ready[k]),
            .i_acc   (s_acc[k]),
            .i_coord (s_coord[k]),
            .i_dest  (s_dest[k]),
            .i_flags (s_flags[k]),
            .o_valid (s_valid[k+1]),
            .i_ready (s_ready[k+1]),
            .o_acc   (s_acc[k+1]),
            .o_coord (s_coord[k+1]),
            .o_dest  (s_dest[k+1]),
            .o_flags (s_flags[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Result: the last multiply-add register is the output register.
    // Offsets wrap at ADDR_W bits, then fit the 32-bit result fields.
    // ------------------------------------------------------------------
    assign s_ready[MAX_DIMS]    = o_out.ready;
    assign o_out.valid          = s_valid[MAX_DIMS];
    assign o_out.source_address = OUT_ADDR_W'(s_acc[MAX_DIMS]);
    assign o_out.dest_address   = OUT_ADDR_W'(s_dest[MAX_DIMS]);
    assign o_out.index_bad      = s_flags[MAX_DIMS].bad;
    assign o_out.last_item      = s_flags[MAX_DIMS].last;

endmodule
`default_nettype wire

FILE: tb/sv/tb_gather_elements_address_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gather_elements_address_generator_top
// Self-checking bench for the gather-elements address generator. A behavioral
// odometer predicts source/destination offsets, the bad-index flag and the
// tensor-end flag for every accepted index item. Results are matched in order
// under random idling on both channels, with one random phase run flat out.
// ----------------------------------------------------------------------------
module tb_gather_elements_address_generator_top;
    import gea_pkg::*;

    localparam int PIPE_LAT     = DEF_MAX_DIMS + 2;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 400;

    typedef struct packed {
        logic [OUT_ADDR_W-1:0] src;
        logic [OUT_ADDR_W-1:0] dst;
        logic                  bad;
        logic                  last;
    } t_addr_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_wdata;

    gea_in_if  idx_ch ();
    gea_out_if addr_ch ();

    gather_elements_address_generator_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (idx_ch),
        .o_out       (addr_ch)
    );

    // Shadow of the block: configuration, odometer and linear position
    logic [AXIS_W-1:0]     axis_sel;
    logic [CFG_W-1:0]      idx_shape;
    logic [CFG_W-1:0]      data_shape;
    logic [15:0]           odo [4];
    logic [OUT_ADDR_W-1:0] lin_pos;

    // Addresses predicted for accepted items, oldest first
    t_addr_result expected_addrs [$];

    // Run statistics
    int mismatches     = 0;
    int items_sent     = 0;
    int random_sent    = 0;
    int results_seen   = 0;
    int tensors_closed = 0;
    int flagged_seen   = 0;
    int cfg_writes     = 0;

    // Idling switches for sender and receiver
    bit src_idle_on = 1'b1;
    bit snk_idle_on = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Outermost dimension sits in the top 16 bits.
    function automatic logic [15:0] dim_extent(input logic [CFG_W-1:0] shape, input int d);
        return shape[(3 - d) * 16 +: 16];
    endfunction

    function void reset_shadow();
        axis_sel   = '0;
        idx_shape  = EXTENTS_RESET;
        data_shape = EXTENTS_RESET;
        for (int d = 0; d < 4; d++) odo[d] = '0;
        lin_pos    = '0;
    endfunction

    // Compute the result for one index item and advance the odometer.
    function t_addr_result predict_addresses(input logic signed [INDEX_W-1:0] value,
                                             input logic first);
        t_addr_result          r;
        logic signed [33:0]    pos;
        logic [15:0]           ext_ax;
        logic [OUT_ADDR_W-1:0] stride;
        logic [OUT_ADDR_W-1:0] sum;
        logic [OUT_ADDR_W-1:0] coord;
        logic                  stepped;
        // restart at the origin before handling this item
        if (first) begin
            for (int d = 0; d < 4; d++) odo[d] = '0;
            lin_pos = '0;
        end
        // wrap a negative index once by the data extent on the axis
        ext_ax = dim_extent(data_shape, int'(axis_sel));
        pos    = value;
        if (pos < 0) pos = pos + $signed({18'd0, ext_ax});
        r.bad = (pos < 0) || (pos >= $signed({18'd0, ext_ax}));
        // row-major offset into the data tensor, innermost dimension first
        sum    = '0;
        stride = 1;
        for (int d = 3; d >= 0; d--) begin
            coord = {16'd0, odo[d]};
            if (d == int'(axis_sel)) coord = r.bad ? '0 : pos[31:0];
            sum    = sum + coord * stride;
            stride = stride * {16'd0, dim_extent(data_shape, d)};
        end
        r.src  = r.bad ? '0 : sum;
        r.dst  = lin_pos;
        // an extent of 0 or 1 counts as finished
        r.last = 1'b1;
        for (int d = 0; d < 4; d++)
            if ({1'b0, odo[d]} + 17'd1 < {1'b0, dim_extent(idx_shape, d)}) r.last = 1'b0;
        // advance; a coordinate past its extent wraps to zero
        stepped = 1'b0;
        for (int d = 3; d >= 0; d--) begin
            if (!stepped) begin
                if ({1'b0, odo[d]} + 17'd1 < {1'b0, dim_extent(idx_shape, d)}) begin
                    odo[d]  = odo[d] + 16'd1;
                    stepped = 1'b1;
                end else begin
                    odo[d] = '0;
                end
            end
        end
        lin_pos = r.last ? '0 : lin_pos + 1;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Channel and register drivers
    // ------------------------------------------------------------------------

    // Offer one item after an optional idle gap, holding valid until accepted; keep valid high afterwards.
    task automatic push_index(input logic [INDEX_W-1:0] value, input logic first);
        int gap;
        gap = 0;
        if (src_idle_on && $urandom_range(99) < 33)
            gap = ($urandom_range(9) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
        if (gap > 0) begin
            idx_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        idx_ch.valid       <= 1'b1;
        idx_ch.index_value <= value;
        idx_ch.first_item  <= first;
        do begin
            @(posedge i_clk);
        end while (!idx_ch.ready);
        expected_addrs.push_back(predict_addresses(value, first));
        items_sent++;
    endtask

    // Drop valid and hold until every predicted result has come back.
    task automatic drain_results();
        idx_ch.valid <= 1'b0;
        while (expected_addrs.size() != 0) @(posedge i_clk);
    endtask

    // Drain, then let the pipeline settle before touching registers.
    task automatic wait_idle();
        drain_results();
        repeat (PIPE_LAT + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_GATHER_AXIS:   axis_sel   = val[AXIS_W-1:0];
            CFG_INDEX_EXTENTS: idx_shape  = val;
            CFG_DATA_EXTENTS:  data_shape = val;
            default: ;
        endcase
        cfg_writes++;
    endtask

    // Program a full shape; upper bits of the axis word are don't-care.
    task automatic set_shape(input logic [AXIS_W-1:0] ax, input logic [CFG_W-1:0] iext,
                             input logic [CFG_W-1:0] dext);
        logic [CFG_W-1:0] axis_word;
        axis_word = {$urandom, $urandom};
        axis_word[AXIS_W-1:0] = ax;
        wait_idle();
        write_reg(CFG_GATHER_AXIS, axis_word);
        write_reg(CFG_INDEX_EXTENTS, iext);
        write_reg(CFG_DATA_EXTENTS, dext);
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result checking and receiver idling
    // ------------------------------------------------------------------------

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h",
                     $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : addr_check
        t_addr_result want;
        if (i_rst_n && addr_ch.valid && addr_ch.ready) begin
            if (expected_addrs.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual src 0x%08h dst 0x%08h",
                         $time, addr_ch.source_address, addr_ch.dest_address);
                mismatches++;
            end else begin
                want = expected_addrs.pop_front();
                check_field("source_address", want.src, addr_ch.source_address);
                check_field("dest_address", want.dst, addr_ch.dest_address);
                check_field("index_bad", {31'd0, want.bad}, {31'd0, addr_ch.index_bad});
                check_field("last_item", {31'd0, want.last}, {31'd0, addr_ch.last_item});
                results_seen++;
                if (want.last) tensors_closed++;
                if (want.bad) flagged_seen++;
            end
        end
        // stall the result channel about a third of the time when idling is on
        addr_ch.ready <= snk_idle_on ? ($urandom_range(99) >= 33) : 1'b1;
    end

    // End the run if no item moves on either channel for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (idx_ch.valid && idx_ch.ready) || (addr_ch.valid && addr_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: watchdog expired with %0d results outstanding",
                 $time, expected_addrs.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset shape is all ones: every item closes a tensor; only 0 and -1 hit.
    task automatic test_reset_shape();
        push_index(32'd0, 1'b1);
        push_index(32'd1, 1'b0);
        push_index(32'hFFFF_FFFF, 1'b0);
        push_index(32'h8000_0000, 1'b0);
    endtask

    // Innermost axis: in-range, wrapped negatives, both out-of-range sides,
    // then a restart flag on the first item of the next tensor.
    task automatic test_index_wrap();
        set_shape(2'd3, {16'd1, 16'd1, 16'd2, 16'd3}, {16'd1, 16'd2, 16'd2, 16'd4});
        push_index(32'd0, 1'b1);
        push_index(32'd3, 1'b0);
        push_index(-32'sd1, 1'b0);
        push_index(-32'sd4, 1'b0);
        push_index(32'd4, 1'b0);
        push_index(-32'sd5, 1'b0);
        push_index(32'h7FFF_FFFF, 1'b1);
        push_index(32'd2, 1'b0);
    endtask

    // Zero data extent on the axis flags every index; a zero index extent
    // counts as finished, like an extent of one.
    task automatic test_zero_axis_extent();
        set_shape(2'd1, {16'd0, 16'd1, 16'd1, 16'd3}, {16'd2, 16'd0, 16'd3, 16'd3});
        push_index(32'd0, 1'b1);
        push_index(-32'sd1, 1'b0);
        push_index(32'd5, 1'b0);
    endtask

    // Widest extents on the outermost axis: the stride overflows 32 bits.
    task automatic test_wide_extents();
        set_shape(2'd0, {4{16'hFFFF}}, {4{16'hFFFF}});
        push_index(32'd65534, 1'b1);
        push_index(-32'sd65535, 1'b0);
        push_index(32'd65535, 1'b0);
        push_index(-32'sd65536, 1'b0);
    endtask

    // Shrink the index shape under a live odometer: the stale coordinate wraps.
    task automatic test_extent_change();
        set_shape(2'd3, {16'd1, 16'd1, 16'd1, 16'd8}, {16'd1, 16'd1, 16'd2, 16'd8});
        push_index(32'd1, 1'b1);
        push_index(32'd7, 1'b0);
        push_index(32'd2, 1'b0);
        push_index(32'd6, 1'b0);
        set_shape(2'd3, {16'd1, 16'd1, 16'd2, 16'd3}, {16'd1, 16'd1, 16'd2, 16'd8});
        push_index(32'd0, 1'b0);
        push_index(32'd5, 1'b0);
        push_index(-32'sd8, 1'b0);
    endtask

    // Random shapes, mostly whole tensors with mostly in-range indexes; some
    // truncated tensors, stray restarts and wild values as noise.
    task automatic test_random_tensors();
        int               phase;
        int               phase_items;
        int               tensor_len;
        int               len;
        int               r;
        int               v;
        logic [AXIS_W-1:0] ax;
        logic [CFG_W-1:0] iext;
        logic [CFG_W-1:0] dext;
        logic [15:0]      e;
        logic             first;
        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            ax = AXIS_W'($urandom_range(3));
            for (int d = 0; d < 4; d++) begin
                iext[(3 - d) * 16 +: 16] = 16'($urandom_range(1, d + 1));
                r = $urandom_range(99);
                if (d == int'(ax))
                    dext[(3 - d) * 16 +: 16] = (r < 10) ? 16'd0 : (r < 20) ? 16'hFFFF :
                                               16'($urandom_range(1, 6));
                else
                    dext[(3 - d) * 16 +: 16] = (r < 5) ? 16'd0 : (r < 12) ? 16'hFFFF :
                                               16'($urandom_range(1, 5));
            end
            if ($urandom_range(19) == 0) iext[16 * $urandom_range(3) +: 16] = 16'd0;
            tensor_len = 1;
            for (int d = 0; d < 4; d++) tensor_len *= int'(dim_extent(iext, d));
            if (tensor_len == 0) tensor_len = 1;
            // one phase runs flat out on both channels
            src_idle_on = (phase != 2);
            snk_idle_on = (phase != 2);
            set_shape(ax, iext, dext);
            e = dim_extent(dext, int'(ax));
            phase_items = 0;
            while (phase_items < 40) begin
                len = ($urandom_range(99) < 4) ? $urandom_range(1, tensor_len) : tensor_len;
                for (int k = 0; k < len; k++) begin
                    // pause mid-tensor until the pipeline is empty
                    if (k == len / 2 && k > 0 && (phase == 0 || $urandom_range(99) < 15))
                        drain_results();
                    first = (k == 0) || ($urandom_range(99) < 4);
                    r = $urandom_range(99);
                    if (r < 70 && e != 0) begin
                        v = $urandom_range(int'(e) - 1);
                        if ($urandom_range(1) == 1) v -= int'(e);
                    end else if (r < 80) begin
                        v = ($urandom_range(1) == 1) ? int'(e) : -int'(e) - 1;
                    end else if (r < 92) begin
                        v = $urandom;
                    end else begin
                        case ($urandom_range(3))
                            0:       v = 32'h7FFF_FFFF;
                            1:       v = 32'h8000_0000;
                            2:       v = -1;
                            default: v = 0;
                        endcase
                    end
                    push_index(v, first);
                end
                phase_items += len;
                random_sent += len;
            end
            phase++;
        end
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = CFG_GATHER_AXIS;
        i_cfg_wdata        = '0;
        idx_ch.valid       = 1'b0;
        idx_ch.index_value = '0;
        idx_ch.first_item  = 1'b0;
        addr_ch.ready      = 1'b0;
        reset_shadow();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_shape();
        test_index_wrap();
        test_zero_axis_extent();
        test_wide_extents();
        test_extent_change();
        test_random_tensors();

        // drain and let any stray result surface
        wait_idle();

        $display("covered %0d index items (%0d random) across %0d register writes",
                 items_sent, random_sent, cfg_writes);
        $display("checked %0d results: %0d tensor ends, %0d flagged indexes, %0d mismatches",
                 results_seen, tensors_closed, flagged_seen, mismatches);
        if (mismatches == 0 && expected_addrs.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
